[rtl/core/cmt_pkg.sv]
// Shared types, constants and arithmetic helpers for the complex Mobius transform.
package cmt_pkg;

    localparam int FRAC      = 16;
    localparam int DIV_STEPS = 2 * FRAC + 1;
    localparam int QW        = DIV_STEPS;
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int NUM_REGS  = 8;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_A_RE = 3'd0;
    localparam t_cfg_idx CFG_A_IM = 3'd1;
    localparam t_cfg_idx CFG_B_RE = 3'd2;
    localparam t_cfg_idx CFG_B_IM = 3'd3;
    localparam t_cfg_idx CFG_C_RE = 3'd4;
    localparam t_cfg_idx CFG_C_IM = 3'd5;
    localparam t_cfg_idx CFG_D_RE = 3'd6;
    localparam t_cfg_idx CFG_D_IM = 3'd7;

    localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_POLE = 2'd2
    } t_status;

    typedef struct packed {
        logic        sat;
        logic [31:0] v;
    } t_sat;

    // numerator and denominator of one point, classified
    typedef struct packed {
        logic [31:0] nr;
        logic [31:0] ni;
        logic [31:0] dr;
        logic [31:0] di;
        logic        sat;
        logic        pole;
    } t_mid;

    function automatic logic signed [65:0] fsh(input logic signed [63:0] p);
        return 66'(p >>> FRAC);
    endfunction

    function automatic t_sat sat32(input logic signed [65:0] x);
        t_sat r;
        r.sat = 1'b0;
        r.v   = x[31:0];
        if (x > 66'sh0_7FFF_FFFF) begin
            r.sat = 1'b1;
            r.v   = 32'h7FFF_FFFF;
        end else if (x < -66'sh0_8000_0000) begin
            r.sat = 1'b1;
            r.v   = 32'h8000_0000;
        end
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? 32'(~v + 32'd1) : v;
    endfunction

endpackage

[rtl/core/cmt_front.sv]
// Front end: coefficient registers, numerator and denominator, pole classification.
module cmt_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  cmt_pkg::t_cfg_idx      i_cfg_index,
    input  logic [31:0]            i_cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic signed [31:0]     i_z_real,
    input  logic signed [31:0]     i_z_imag,
    input  logic                   i_q_full,
    output logic                   o_q_push,
    output cmt_pkg::t_mid          o_item
);

    logic signed [31:0] r_coef [cmt_pkg::NUM_REGS];
    logic               r_f1_v, r_f2_v;
    logic signed [63:0] r_p [8];
    logic signed [63:0] n_p [8];
    cmt_pkg::t_mid      r_f2, n_f2;
    cmt_pkg::t_sat      s_nr, s_ni, s_dr, s_di;
    logic               en;

    assign en       = !(r_f2_v && i_q_full);
    assign full     = !en;
    assign o_q_push = r_f2_v && !i_q_full;
    assign o_item   = r_f2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cmt_pkg::NUM_REGS; k++) begin
                r_coef[k] <= '0;
            end
            r_coef[cmt_pkg::CFG_A_RE] <= cmt_pkg::ONE_FX;
            r_coef[cmt_pkg::CFG_D_RE] <= cmt_pkg::ONE_FX;
        end else if (i_cfg_valid) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        n_p[0] = r_coef[cmt_pkg::CFG_A_RE] * i_z_real;
        n_p[1] = r_coef[cmt_pkg::CFG_A_IM] * i_z_imag;
        n_p[2] = r_coef[cmt_pkg::CFG_A_RE] * i_z_imag;
        n_p[3] = r_coef[cmt_pkg::CFG_A_IM] * i_z_real;
        n_p[4] = r_coef[cmt_pkg::CFG_C_RE] * i_z_real;
        n_p[5] = r_coef[cmt_pkg::CFG_C_IM] * i_z_imag;
        n_p[6] = r_coef[cmt_pkg::CFG_C_RE] * i_z_imag;
        n_p[7] = r_coef[cmt_pkg::CFG_C_IM] * i_z_real;
    end

    always_comb begin
        s_nr = cmt_pkg::sat32(cmt_pkg::fsh(r_p[0]) - cmt_pkg::fsh(r_p[1])
                              + 66'(r_coef[cmt_pkg::CFG_B_RE]));
        s_ni = cmt_pkg::sat32(cmt_pkg::fsh(r_p[2]) + cmt_pkg::fsh(r_p[3])
                              + 66'(r_coef[cmt_pkg::CFG_B_IM]));
        s_dr = cmt_pkg::sat32(cmt_pkg::fsh(r_p[4]) - cmt_pkg::fsh(r_p[5])
                              + 66'(r_coef[cmt_pkg::CFG_D_RE]));
        s_di = cmt_pkg::sat32(cmt_pkg::fsh(r_p[6]) + cmt_pkg::fsh(r_p[7])
                              + 66'(r_coef[cmt_pkg::CFG_D_IM]));
        n_f2.nr   = s_nr.v;
        n_f2.ni   = s_ni.v;
        n_f2.dr   = s_dr.v;
        n_f2.di   = s_di.v;
        n_f2.sat  = s_nr.sat | s_ni.sat | s_dr.sat | s_di.sat;
        n_f2.pole = (s_dr.v == '0) && (s_di.v == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (en) begin
            r_f1_v <= push;
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p  <= n_p;
            r_f2 <= n_f2;
        end
    end

endmodule

[rtl/core/cmt_queue.sv]
// Short queue between the front end and the back end.
module cmt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cmt_pkg::t_mid i_item,
    output logic          o_full,
    input  logic          i_pop,
    output cmt_pkg::t_mid o_item,
    output logic          o_empty
);

    cmt_pkg::t_mid              r_mem [cmt_pkg::QDEPTH];
    logic [cmt_pkg::QAW-1:0]    r_wp, r_rp;
    logic [cmt_pkg::QAW:0]      r_cnt;
    logic                       wr, rd;

    assign o_full  = (r_cnt == (cmt_pkg::QAW+1)'(cmt_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            if (wr && !rd) r_cnt <= r_cnt + 1'b1;
            else if (rd && !wr) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_item;
    end

endmodule

[rtl/core/cmt_back.sv]
// Back end: squared magnitude, pipelined reciprocal divider, final product, result queue.
module cmt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  cmt_pkg::t_mid      i_item,
    output logic               o_q_pop,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_w_real,
    output logic signed [31:0] o_w_imag,
    output logic [1:0]         o_status
);

    typedef struct packed {
        logic [64:0]             rem_r;
        logic [64:0]             rem_i;
        logic [cmt_pkg::QW-1:0]  q_r;
        logic [cmt_pkg::QW-1:0]  q_i;
        logic [63:0]             mag;
        logic [31:0]             nr;
        logic [31:0]             ni;
        logic                    neg_r;
        logic                    neg_i;
        logic                    sat;
        logic                    pole;
    } t_dv;

    typedef struct packed {
        logic [31:0] w_r;
        logic [31:0] w_i;
        logic [1:0]  status;
    } t_res;

    function automatic t_dv dv_step(input t_dv s, input logic sh);
        t_dv         o;
        logic [64:0] rr;
        logic [64:0] ri;
        o  = s;
        rr = sh ? {s.rem_r[63:0], 1'b0} : s.rem_r;
        ri = sh ? {s.rem_i[63:0], 1'b0} : s.rem_i;
        if (rr >= {1'b0, s.mag}) begin
            o.rem_r = rr - {1'b0, s.mag};
            o.q_r   = {s.q_r[cmt_pkg::QW-2:0], 1'b1};
        end else begin
            o.rem_r = rr;
            o.q_r   = {s.q_r[cmt_pkg::QW-2:0], 1'b0};
        end
        if (ri >= {1'b0, s.mag}) begin
            o.rem_i = ri - {1'b0, s.mag};
            o.q_i   = {s.q_i[cmt_pkg::QW-2:0], 1'b1};
        end else begin
            o.rem_i = ri;
            o.q_i   = {s.q_i[cmt_pkg::QW-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic cmt_pkg::t_sat rsat(input logic [cmt_pkg::QW-1:0] q, input logic neg);
        cmt_pkg::t_sat r;
        logic [63:0]   qe;
        qe    = 64'(q);
        r.sat = 1'b0;
        r.v   = qe[31:0];
        if (!neg) begin
            if (qe > 64'h7FFF_FFFF) begin
                r.sat = 1'b1;
                r.v   = 32'h7FFF_FFFF;
            end
        end else if (qe > 64'h8000_0000) begin
            r.sat = 1'b1;
            r.v   = 32'h8000_0000;
        end else begin
            r.v = 32'(~qe[31:0] + 32'd1);
        end
        return r;
    endfunction

    logic                          en;
    logic                          r_b1_v, r_b2_v, r_r_v, r_m1_v;
    cmt_pkg::t_mid                 r_b1;
    logic signed [63:0]            r_sq_r, r_sq_i;
    t_dv                           r_b2, n_b2;
    logic [cmt_pkg::DIV_STEPS-1:0] r_dv_v;
    t_dv                           r_dv [cmt_pkg::DIV_STEPS];
    t_dv                           n_dv [cmt_pkg::DIV_STEPS];
    cmt_pkg::t_sat                 s_rr, s_ri;
    logic signed [31:0]            r_rr, r_ri, r_nr, r_ni;
    logic                          r_r_sat, r_r_pole, r_m1_sat, r_m1_pole;
    logic signed [63:0]            r_p [4];
    cmt_pkg::t_sat                 s_wr, s_wi;
    t_res                          n_res;
    t_res                          r_ob [2];
    logic                          r_wp, r_rp;
    logic [1:0]                    r_cnt;
    logic                          push_res, pop_res;

    assign en       = !(r_m1_v && (r_cnt == 2'd2));
    assign o_q_pop  = en && !i_q_empty;
    assign push_res = r_m1_v && en;
    assign pop_res  = pop && !empty;

    always_comb begin
        n_b2.mag   = 64'($unsigned(r_sq_r)) + 64'($unsigned(r_sq_i));
        n_b2.rem_r = 65'(cmt_pkg::abs32(r_b1.dr));
        n_b2.rem_i = 65'(cmt_pkg::abs32(r_b1.di));
        n_b2.q_r   = '0;
        n_b2.q_i   = '0;
        n_b2.nr    = r_b1.nr;
        n_b2.ni    = r_b1.ni;
        n_b2.neg_r = r_b1.dr[31];
        n_b2.neg_i = !r_b1.di[31];
        n_b2.sat   = r_b1.sat;
        n_b2.pole  = r_b1.pole;
    end

    for (genvar k = 0; k < cmt_pkg::DIV_STEPS; k++) begin : g_div
        if (k == 0) begin : g_first
            assign n_dv[k] = dv_step(r_b2, 1'b0);
        end else begin : g_next
            assign n_dv[k] = dv_step(r_dv[k-1], 1'b1);
        end
    end

    assign s_rr = rsat(r_dv[cmt_pkg::DIV_STEPS-1].q_r, r_dv[cmt_pkg::DIV_STEPS-1].neg_r);
    assign s_ri = rsat(r_dv[cmt_pkg::DIV_STEPS-1].q_i, r_dv[cmt_pkg::DIV_STEPS-1].neg_i);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_dv_v <= '0;
            r_r_v  <= 1'b0;
            r_m1_v <= 1'b0;
        end else if (en) begin
            r_b1_v <= !i_q_empty;
            r_b2_v <= r_b1_v;
            r_dv_v <= {r_dv_v[cmt_pkg::DIV_STEPS-2:0], r_b2_v};
            r_r_v  <= r_dv_v[cmt_pkg::DIV_STEPS-1];
            r_m1_v <= r_r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1      <= i_item;
            r_sq_r    <= $signed(i_item.dr) * $signed(i_item.dr);
            r_sq_i    <= $signed(i_item.di) * $signed(i_item.di);
            r_b2      <= n_b2;
            r_dv      <= n_dv;
            r_rr      <= s_rr.v;
            r_ri      <= s_ri.v;
            r_nr      <= r_dv[cmt_pkg::DIV_STEPS-1].nr;
            r_ni      <= r_dv[cmt_pkg::DIV_STEPS-1].ni;
            r_r_sat   <= r_dv[cmt_pkg::DIV_STEPS-1].sat | s_rr.sat | s_ri.sat;
            r_r_pole  <= r_dv[cmt_pkg::DIV_STEPS-1].pole;
            r_p[0]    <= r_nr * r_rr;
            r_p[1]    <= r_ni * r_ri;
            r_p[2]    <= r_nr * r_ri;
            r_p[3]    <= r_ni * r_rr;
            r_m1_sat  <= r_r_sat;
            r_m1_pole <= r_r_pole;
        end
    end

    always_comb begin
        s_wr = cmt_pkg::sat32(cmt_pkg::fsh(r_p[0]) - cmt_pkg::fsh(r_p[1]));
        s_wi = cmt_pkg::sat32(cmt_pkg::fsh(r_p[2]) + cmt_pkg::fsh(r_p[3]));
        if (r_m1_pole) begin
            n_res.w_r    = '0;
            n_res.w_i    = '0;
            n_res.status = cmt_pkg::ST_POLE;
        end else begin
            n_res.w_r    = s_wr.v;
            n_res.w_i    = s_wi.v;
            n_res.status = (r_m1_sat | s_wr.sat | s_wi.sat) ? cmt_pkg::ST_SAT : cmt_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push_res) r_wp <= !r_wp;
            if (pop_res)  r_rp <= !r_rp;
            if (push_res && !pop_res) r_cnt <= r_cnt + 2'd1;
            else if (pop_res && !push_res) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_res) r_ob[r_wp] <= n_res;
    end

    assign empty    = (r_cnt == 2'd0);
    assign o_w_real = r_ob[r_rp].w_r;
    assign o_w_imag = r_ob[r_rp].w_i;
    assign o_status = r_ob[r_rp].status;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("result queue overfilled");

    a_pole_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == cmt_pkg::ST_POLE) |-> (o_w_real == '0 && o_w_imag == '0))
        else $error("pole result not zero");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_res && !push_res) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("result queue count wrong after pop");

endmodule

[rtl/core/complex_mobius_transform.sv]
// Top level of the complex Mobius transform w = (a*z + b) / (c*z + d).
// Takes one point per cycle while full is low and returns one result per point, in
// order. Points and results are signed Q16.16. The reciprocal divider resolves one
// quotient bit per stage for 2*FRAC+1 stages. A 4-entry queue between front end and
// divider lets each side stall on its own; a 2-entry result queue holds finished
// points.
// Coefficients are written through the cfg channel, which is always ready;
// write them only while no transaction is in flight.
module complex_mobius_transform (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_z_real,
    input  logic signed [31:0] i_z_imag,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_w_real,
    output logic signed [31:0] o_w_imag,
    output logic [1:0]         o_status
);

    cmt_pkg::t_mid f_item, q_item;
    logic          q_push, q_full, q_pop, q_empty;

    assign o_cfg_ready = 1'b1;

    cmt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_z_real    (i_z_real),
        .i_z_imag    (i_z_imag),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_item      (f_item)
    );

    cmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    cmt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_item    (q_item),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_w_real  (o_w_real),
        .o_w_imag  (o_w_imag),
        .o_status  (o_status)
    );

endmodule

[verif/cmt_checker.sv]
// Checker for the complex Mobius transform: predicts every point and compares results.
`timescale 1ns / 1ps
module cmt_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_push,
    input  logic               i_full,
    input  logic signed [31:0] i_z_real,
    input  logic signed [31:0] i_z_imag,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic signed [31:0] i_w_real,
    input  logic signed [31:0] i_w_imag,
    input  logic [1:0]         i_status,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_poles,
    output int                 o_clipped
);

    typedef struct {
        logic signed [31:0] w_real;
        logic signed [31:0] w_imag;
        cmt_pkg::t_status   status;
    } t_point;

    longint coef [cmt_pkg::NUM_REGS];
    t_point w_expected[$];

    function automatic longint floor_scale(input longint x);
        return x >>> cmt_pkg::FRAC;
    endfunction

    function automatic longint clip32(input longint x, inout bit clipped);
        if (x > 64'sd2147483647) begin
            clipped = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            clipped = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // (mag << 2*FRAC) / den, quotient growth frozen once bit 40 is set
    function automatic longint unsigned scaled_quot(input longint unsigned mag,
                                                    input longint unsigned den);
        logic [127:0]    dividend;
        longint unsigned rem;
        longint unsigned q;
        bit              qb;
        dividend = {64'd0, mag} << (2 * cmt_pkg::FRAC);
        rem = 0;
        q   = 0;
        for (int i = 127; i >= 0; i--) begin
            rem = (rem << 1) | 64'(dividend[i]);
            qb  = 1'b0;
            if (rem >= den) begin
                rem = rem - den;
                qb  = 1'b1;
            end
            if ((q >> 40) == 0) q = (q << 1) | 64'(qb);
        end
        return q;
    endfunction

    function automatic longint recip_part(input longint v, input bit negate,
                                          input longint unsigned mag2, inout bit clipped);
        longint unsigned m;
        longint          q;
        bit              neg;
        m   = (v < 0) ? longint'(-v) : longint'(v);
        q   = longint'(scaled_quot(m, mag2));
        neg = (v < 0) != negate;
        return clip32(neg ? -q : q, clipped);
    endfunction

    function automatic t_point transform_point(input longint zr, input longint zi);
        t_point          p;
        bit              clipped;
        longint          nr, ni, dr, di, rr, ri;
        longint unsigned mag2;
        clipped = 1'b0;
        nr = clip32(floor_scale(coef[cmt_pkg::CFG_A_RE] * zr)
                    - floor_scale(coef[cmt_pkg::CFG_A_IM] * zi)
                    + coef[cmt_pkg::CFG_B_RE], clipped);
        ni = clip32(floor_scale(coef[cmt_pkg::CFG_A_RE] * zi)
                    + floor_scale(coef[cmt_pkg::CFG_A_IM] * zr)
                    + coef[cmt_pkg::CFG_B_IM], clipped);
        dr = clip32(floor_scale(coef[cmt_pkg::CFG_C_RE] * zr)
                    - floor_scale(coef[cmt_pkg::CFG_C_IM] * zi)
                    + coef[cmt_pkg::CFG_D_RE], clipped);
        di = clip32(floor_scale(coef[cmt_pkg::CFG_C_RE] * zi)
                    + floor_scale(coef[cmt_pkg::CFG_C_IM] * zr)
                    + coef[cmt_pkg::CFG_D_IM], clipped);
        if (dr == 0 && di == 0) begin
            p.w_real = '0;
            p.w_imag = '0;
            p.status = cmt_pkg::ST_POLE;
            return p;
        end
        mag2 = longint'(dr * dr) + longint'(di * di);
        rr = recip_part(dr, 1'b0, mag2, clipped);
        ri = recip_part(di, 1'b1, mag2, clipped);
        p.w_real = 32'(clip32(floor_scale(nr * rr) - floor_scale(ni * ri), clipped));
        p.w_imag = 32'(clip32(floor_scale(nr * ri) + floor_scale(ni * rr), clipped));
        p.status = clipped ? cmt_pkg::ST_SAT : cmt_pkg::ST_OK;
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_point e;
        int     errs;
        errs = 0;
        if (!i_rst_n) begin
            foreach (coef[k]) coef[k] = 0;
            coef[cmt_pkg::CFG_A_RE] = longint'(cmt_pkg::ONE_FX);
            coef[cmt_pkg::CFG_D_RE] = longint'(cmt_pkg::ONE_FX);
            w_expected.delete();
            o_errors  <= 0;
            o_pending <= 0;
            o_poles   <= 0;
            o_clipped <= 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (w_expected.size() == 0) begin
                    $error("result transaction with no point outstanding");
                    errs++;
                end else begin
                    e = w_expected.pop_front();
                    if (i_w_real !== e.w_real) begin
                        $error("w_real: expected %0d, got %0d", e.w_real, i_w_real);
                        errs++;
                    end
                    if (i_w_imag !== e.w_imag) begin
                        $error("w_imag: expected %0d, got %0d", e.w_imag, i_w_imag);
                        errs++;
                    end
                    if (i_status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, i_status);
                        errs++;
                    end
                    if (e.status == cmt_pkg::ST_POLE) o_poles <= o_poles + 1;
                    if (e.status == cmt_pkg::ST_SAT) o_clipped <= o_clipped + 1;
                end
            end
            if (i_push && !i_full) w_expected.push_back(transform_point(i_z_real, i_z_imag));
            if (i_cfg_valid && i_cfg_ready) coef[i_cfg_index] = longint'($signed(i_cfg_data));
            o_errors  <= o_errors + errs;
            o_pending <= w_expected.size();
        end
    end

endmodule

[verif/tb_complex_mobius_transform.sv]
// Testbench top for the complex Mobius transform: stimulus, coefficient sets and verdict.
`timescale 1ns / 1ps
module tb_complex_mobius_transform;

    localparam int DRAIN_CYCLES = 60;
    localparam int IDLE_LIMIT   = 3000;
    localparam int RAND_POINTS  = 236;
    localparam logic [31:0] FX_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] FX_MIN = 32'h8000_0000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               push = 1'b0;
    logic               full;
    logic signed [31:0] i_z_real = '0;
    logic signed [31:0] i_z_imag = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [31:0] o_w_real;
    logic signed [31:0] o_w_imag;
    logic [1:0]         o_status;

    int errors, pending, poles, clipped;
    int points_sent = 0;
    int coef_sets = 0;
    int idle_cycles = 0;
    int rx_cycle = 0;
    int rx_mode = 0;

    always #10 i_clk = ~i_clk;

    complex_mobius_transform u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_z_real    (i_z_real),
        .i_z_imag    (i_z_imag),
        .empty       (empty),
        .pop         (pop),
        .o_w_real    (o_w_real),
        .o_w_imag    (o_w_imag),
        .o_status    (o_status)
    );

    cmt_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_full      (full),
        .i_z_real    (i_z_real),
        .i_z_imag    (i_z_imag),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_w_real    (o_w_real),
        .i_w_imag    (o_w_imag),
        .i_status    (o_status),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_poles     (poles),
        .o_clipped   (clipped)
    );

    // receiver: pop follows a stall pattern drawn at random from four modes
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            case (rx_mode)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 1) == 1);
                2: pop <= ($urandom_range(0, 3) == 0);
                default: pop <= rx_cycle[3];
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [31:0] fx_value();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0, 1: v = $urandom;
            2: begin
                case ($urandom_range(0, 4))
                    0: v = FX_MAX;
                    1: v = FX_MIN;
                    2: v = '0;
                    3: v = cmt_pkg::ONE_FX;
                    default: v = -cmt_pkg::ONE_FX;
                endcase
            end
            default: begin
                v = $urandom_range(0, 4 * 65536);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic write_coef(input cmt_pkg::t_cfg_idx idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_coefs(input logic [31:0] c [8]);
        wait_idle();
        write_coef(cmt_pkg::CFG_A_RE, c[0]);
        write_coef(cmt_pkg::CFG_A_IM, c[1]);
        write_coef(cmt_pkg::CFG_B_RE, c[2]);
        write_coef(cmt_pkg::CFG_B_IM, c[3]);
        write_coef(cmt_pkg::CFG_C_RE, c[4]);
        write_coef(cmt_pkg::CFG_C_IM, c[5]);
        write_coef(cmt_pkg::CFG_D_RE, c[6]);
        write_coef(cmt_pkg::CFG_D_IM, c[7]);
        coef_sets++;
    endtask

    task automatic send_point(input logic [31:0] zr, input logic [31:0] zi);
        push     <= 1'b1;
        i_z_real <= zr;
        i_z_imag <= zi;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        points_sent++;
    endtask

    task automatic send_directed();
        logic [31:0] zr [10] = '{32'd0, FX_MAX, FX_MIN, cmt_pkg::ONE_FX, -cmt_pkg::ONE_FX,
                                 FX_MAX, FX_MIN, 32'h0000_8000, 32'd1, 32'hFFFF_FFFF};
        logic [31:0] zi [10] = '{32'd0, FX_MAX, FX_MIN, 32'd0, cmt_pkg::ONE_FX,
                                 FX_MIN, FX_MAX, 32'hFFFF_8000, 32'hFFFF_FFFF, 32'd1};
        for (int k = 0; k < 10; k++) send_point(zr[k], zi[k]);
        push <= 1'b0;
    endtask

    task automatic send_random(input int count, input bit hold_off);
        int left, burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            if (burst > left) burst = left;
            for (int k = 0; k < burst; k++) send_point(fx_value(), fx_value());
            left -= burst;
            push <= 1'b0;
            if (hold_off && left < count / 2) begin
                hold_off = 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end else if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        logic [31:0] c [8];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset coefficients: identity map
        send_directed();
        send_random(RAND_POINTS, 1'b0);

        c = '{32'h0002_0000, 32'hFFFF_8000, 32'h0000_4000, cmt_pkg::ONE_FX,
              32'h0000_8000, 32'h0000_8000, cmt_pkg::ONE_FX, -cmt_pkg::ONE_FX};
        load_coefs(c);
        send_random(RAND_POINTS, 1'b1);

        c = '{FX_MAX, FX_MIN, FX_MIN, FX_MAX, FX_MAX, FX_MAX, FX_MIN, FX_MIN};
        load_coefs(c);
        send_random(RAND_POINTS, 1'b0);

        // denominator always zero
        c = '{cmt_pkg::ONE_FX, 32'h0003_0000, 32'h0001_8000, FX_MIN,
              32'd0, 32'd0, 32'd0, 32'd0};
        load_coefs(c);
        send_random(RAND_POINTS / 2, 1'b0);

        // pole at z = 0
        c = '{cmt_pkg::ONE_FX, 32'd0, cmt_pkg::ONE_FX, 32'd0, cmt_pkg::ONE_FX,
              32'd0, 32'd0, 32'd0};
        load_coefs(c);
        send_directed();
        send_random(RAND_POINTS, 1'b0);

        for (int s = 0; s < 2; s++) begin
            foreach (c[k]) c[k] = (s == 0) ? $urandom : fx_value();
            load_coefs(c);
            send_random(RAND_POINTS, 1'b0);
        end

        wait_idle();
        $display("covered %0d points over %0d coefficient sets plus reset values",
                 points_sent, coef_sets);
        $display("%0d pole results and %0d saturated results checked", poles, clipped);
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/cmt_pkg.sv
rtl/core/cmt_front.sv
rtl/core/cmt_queue.sv
rtl/core/cmt_back.sv
rtl/core/complex_mobius_transform.sv
verif/cmt_checker.sv
verif/tb_complex_mobius_transform.sv
